@@ rtl/ordm_pkg.sv @@
// Shared codes and enumerated types for the order book matcher.
package ordm_pkg;

  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_CANCEL = 2'd1,
    REQ_MODIFY = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    OT_LIMIT  = 2'd0,
    OT_MARKET = 2'd1,
    OT_IOC    = 2'd2,
    OT_FOK    = 2'd3
  } ord_type_t;

  typedef enum logic [3:0] {
    STAT_RESTED    = 4'd0,
    STAT_PARTIAL   = 4'd1,
    STAT_FILLED    = 4'd2,
    STAT_CANCELLED = 4'd3,
    STAT_FOK_REJ   = 4'd4,
    STAT_INVALID   = 4'd5,
    STAT_NOT_FOUND = 4'd6,
    STAT_MODIFIED  = 4'd7,
    STAT_BOOK_FULL = 4'd8
  } status_t;

  localparam logic RK_TRADE  = 1'b0;
  localparam logic RK_STATUS = 1'b1;

  localparam logic SIDE_BUY = 1'b0;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_EVAL
  } eng_state_t;

  typedef enum logic [1:0] {
    STG_FIRST,
    STG_CROSS,
    STG_TOP
  } stage_t;

endpackage

@@ rtl/ordm_if.sv @@
// Request and result channel interfaces of the order book matcher.
interface ordm_req_if #(
  parameter int PRICE_BITS = 16,
  parameter int QTY_BITS   = 20,
  parameter int ID_BITS    = 32
);
  logic                  valid;
  logic                  ready;
  logic [1:0]            req_type;
  logic [ID_BITS-1:0]    ord_id;
  logic                  side;
  logic [1:0]            order_type;
  logic [PRICE_BITS-1:0] price;
  logic [QTY_BITS-1:0]   quantity;
  logic [QTY_BITS-1:0]   unfilled_qty;

  modport source (output valid, req_type, ord_id, side, order_type, price, quantity,
                  unfilled_qty, input ready);
  modport sink (input valid, req_type, ord_id, side, order_type, price, quantity,
                unfilled_qty, output ready);
endinterface

interface ordm_res_if #(
  parameter int PRICE_BITS = 16,
  parameter int QTY_BITS   = 20,
  parameter int ID_BITS    = 32
);
  logic                  valid;
  logic                  ready;
  logic                  result_kind;
  logic [ID_BITS-1:0]    aggressor_id;
  logic [ID_BITS-1:0]    resting_id;
  logic [PRICE_BITS-1:0] trade_price;
  logic [QTY_BITS-1:0]   trade_qty;
  logic [QTY_BITS-1:0]   left_qty;
  logic [3:0]            status;
  logic [PRICE_BITS-1:0] best_bid;
  logic [PRICE_BITS-1:0] best_ask;
  logic                  bid_present;
  logic                  ask_present;
  logic                  last_result;

  modport source (output valid, result_kind, aggressor_id, resting_id, trade_price,
                  trade_qty, left_qty, status, best_bid, best_ask, bid_present,
                  ask_present, last_result, input ready);
  modport sink (input valid, result_kind, aggressor_id, resting_id, trade_price,
                trade_qty, left_qty, status, best_bid, best_ask, bid_present,
                ask_present, last_result, output ready);
endinterface

@@ rtl/ordm_fifo.sv @@
// Two-entry queue between the request front end and the matching engine.
module ordm_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             not_empty
);
  localparam int DEPTH = 2;
  localparam int PW    = $clog2(DEPTH);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PW-1:0]    wp, rp;
  logic [PW:0]      count;

  assign full      = (count == (PW+1)'(DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = entries[rp];

  always_ff @(posedge clk) begin
    if (push) entries[wp] <= push_data;
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop)  rp <= rp + 1'b1;
      count <= count + (PW+1)'(push) - (PW+1)'(pop);
    end
  end
endmodule

@@ rtl/ordm_front.sv @@
// Request front end: takes items, assigns automatic identifiers and fills defaults.
module ordm_front import ordm_pkg::*; #(
  parameter int PRICE_BITS = 16,
  parameter int QTY_BITS   = 20,
  parameter int ID_BITS    = 32,
  localparam int REQ_W     = 2 + ID_BITS + 1 + 2 + PRICE_BITS + 2 * QTY_BITS
) (
  input  logic             clk,
  input  logic             rst,
  ordm_req_if.sink         req,
  output logic             push,
  output logic [REQ_W-1:0] push_data,
  input  logic             full
);
  logic [ID_BITS-1:0] next_auto_id, next_auto_id_next, id_inc;
  logic               is_add, auto_id;
  logic [ID_BITS-1:0] id_eff;
  logic [QTY_BITS-1:0] rem_eff;

  assign req.ready = !full;
  assign push      = req.valid && !full;
  assign is_add    = (req.req_type == REQ_ADD);
  assign auto_id   = is_add && (req.ord_id == '0);
  assign id_eff    = auto_id ? next_auto_id : req.ord_id;
  assign rem_eff   = (is_add && req.unfilled_qty == '0) ? req.quantity : req.unfilled_qty;
  assign push_data = {req.req_type, id_eff, req.side, req.order_type, req.price,
                      req.quantity, rem_eff};

  // The counter skips zero when it wraps.
  assign id_inc            = next_auto_id + 1'b1;
  assign next_auto_id_next = (id_inc == '0) ? ID_BITS'(1) : id_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      next_auto_id <= ID_BITS'(1);
    end else if (push && auto_id) begin
      next_auto_id <= next_auto_id_next;
    end
  end
endmodule

@@ rtl/ordm_engine.sv @@
// Matching engine: scans the slot store and sequences trades and status items.
module ordm_engine import ordm_pkg::*; #(
  parameter int ORDER_SLOTS = 32,
  parameter int PRICE_BITS  = 16,
  parameter int QTY_BITS    = 20,
  parameter int ID_BITS     = 32,
  localparam int REQ_W      = 2 + ID_BITS + 1 + 2 + PRICE_BITS + 2 * QTY_BITS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  logic [REQ_W-1:0] q_data,
  output logic             q_pop,
  ordm_res_if.source       res
);
  localparam int IDXW = (ORDER_SLOTS > 1) ? $clog2(ORDER_SLOTS) : 1;
  localparam int CNTW = IDXW + 1;
  localparam int AVW  = QTY_BITS + IDXW;
  localparam logic [CNTW-1:0] NSLOT    = CNTW'(ORDER_SLOTS);
  localparam logic [CNTW-1:0] LASTSLOT = CNTW'(ORDER_SLOTS - 1);

  typedef struct packed {
    logic                  valid;
    logic [ID_BITS-1:0]    id;
    logic                  side;
    logic [PRICE_BITS-1:0] price;
    logic [QTY_BITS-1:0]   total;
    logic [QTY_BITS-1:0]   left;
    logic [31:0]           arrival;
  } slot_t;

  typedef struct packed {
    logic [1:0]            req_type;
    logic [ID_BITS-1:0]    id;
    logic                  side;
    logic [1:0]            otype;
    logic [PRICE_BITS-1:0] price;
    logic [QTY_BITS-1:0]   qty;
    logic [QTY_BITS-1:0]   rem;
  } req_w_t;

  slot_t mem [ORDER_SLOTS];
  slot_t rdata, wdata;
  logic [IDXW-1:0] raddr, waddr;
  logic we;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  eng_state_t state, state_next;
  stage_t     stg, stg_next;
  logic [CNTW-1:0] cnt, cnt_next;
  logic            pv, pv_next;
  logic [IDXW-1:0] pidx;

  logic            match_hit, match_hit_next, best_hit, best_hit_next;
  logic            free_hit, free_hit_next, bid_hit, bid_hit_next, ask_hit, ask_hit_next;
  logic [IDXW-1:0] match_idx, match_idx_next, best_idx, best_idx_next;
  logic [IDXW-1:0] free_idx, free_idx_next;
  slot_t           match_w, match_w_next, best_w, best_w_next;
  logic [AVW-1:0]  avail, avail_next;
  logic [PRICE_BITS-1:0] bid_px, bid_px_next, ask_px, ask_px_next;

  req_t                  c_req, c_req_next;
  logic [ID_BITS-1:0]    c_id, c_id_next;
  logic                  c_side, c_side_next;
  ord_type_t             c_otype, c_otype_next;
  logic [PRICE_BITS-1:0] c_price, c_price_next;
  logic [QTY_BITS-1:0]   c_qty, c_qty_next, c_rem, c_rem_next;
  status_t               c_stat, c_stat_next;
  logic [QTY_BITS-1:0]   c_left, c_left_next;
  logic [31:0]           arr_cnt, arr_next;

  logic o_valid, out_busy, load_trade, load_status, go_scan, do_cross;
  logic [QTY_BITS-1:0] fill, rem_new, filled, mod_left;
  logic [PRICE_BITS-1:0] newp;
  logic c_mkt, crossing, better, add_bad;
  logic [31:0] age_s, age_b;
  req_w_t qd;

  assign qd       = q_data;
  assign out_busy = o_valid && !res.ready;
  assign res.valid = o_valid;
  assign c_mkt    = (c_otype == OT_MARKET);
  assign fill     = (c_rem < best_w.left) ? c_rem : best_w.left;
  assign rem_new  = c_rem - fill;
  assign filled   = match_w.total - match_w.left;
  assign mod_left = c_qty - filled;
  assign newp     = (c_price != '0) ? c_price : match_w.price;
  assign add_bad  = (c_qty == '0) || (c_rem == '0) || (c_rem > c_qty) ||
                    (!c_mkt && c_price == '0) || match_hit;

  // Per-slot classification of the word coming out of the store.
  assign crossing = rdata.valid && (rdata.side != c_side) &&
                    (c_mkt || ((c_side == SIDE_BUY) ? (rdata.price <= c_price)
                                                    : (rdata.price >= c_price)));
  assign age_s    = arr_cnt - rdata.arrival;
  assign age_b    = arr_cnt - best_w.arrival;
  assign better   = !best_hit ||
                    ((rdata.price != best_w.price) ?
                     ((c_side == SIDE_BUY) ? (rdata.price < best_w.price)
                                           : (rdata.price > best_w.price))
                     : (age_s > age_b));

  always_comb begin
    state_next = state;   stg_next = stg;   cnt_next = cnt;   pv_next = 1'b0;
    match_hit_next = match_hit; match_idx_next = match_idx; match_w_next = match_w;
    best_hit_next = best_hit;   best_idx_next = best_idx;   best_w_next = best_w;
    free_hit_next = free_hit;   free_idx_next = free_idx;   avail_next = avail;
    bid_hit_next = bid_hit; bid_px_next = bid_px; ask_hit_next = ask_hit; ask_px_next = ask_px;
    c_req_next = c_req; c_id_next = c_id; c_side_next = c_side; c_otype_next = c_otype;
    c_price_next = c_price; c_qty_next = c_qty; c_rem_next = c_rem;
    c_stat_next = c_stat; c_left_next = c_left; arr_next = arr_cnt;
    we = 1'b0; waddr = best_idx; wdata = best_w; raddr = cnt[IDXW-1:0];
    q_pop = 1'b0; load_trade = 1'b0; load_status = 1'b0; go_scan = 1'b0; do_cross = 1'b0;

    unique case (state)
      S_CLEAR: begin
        we       = 1'b1;
        waddr    = cnt[IDXW-1:0];
        wdata    = '0;
        cnt_next = cnt + 1'b1;
        if (cnt == LASTSLOT) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (q_valid) begin
          q_pop        = 1'b1;
          c_req_next   = req_t'(qd.req_type);
          c_id_next    = qd.id;
          c_side_next  = qd.side;
          c_otype_next = ord_type_t'(qd.otype);
          c_price_next = qd.price;
          c_qty_next   = qd.qty;
          c_rem_next   = qd.rem;
          stg_next     = STG_FIRST;
          go_scan      = 1'b1;
        end
      end
      S_SCAN: begin
        if (cnt != NSLOT) begin
          pv_next  = 1'b1;
          cnt_next = cnt + 1'b1;
        end
        if (pv) begin
          if (rdata.valid && rdata.id == c_id) begin
            match_hit_next = 1'b1; match_idx_next = pidx; match_w_next = rdata;
          end
          if (crossing) begin
            avail_next = avail + AVW'(rdata.left);
            if (better) begin
              best_hit_next = 1'b1; best_idx_next = pidx; best_w_next = rdata;
            end
          end
          if (!rdata.valid && !free_hit) begin
            free_hit_next = 1'b1; free_idx_next = pidx;
          end
          if (rdata.valid && rdata.side == SIDE_BUY && (!bid_hit || rdata.price > bid_px)) begin
            bid_hit_next = 1'b1; bid_px_next = rdata.price;
          end
          if (rdata.valid && rdata.side != SIDE_BUY && (!ask_hit || rdata.price < ask_px)) begin
            ask_hit_next = 1'b1; ask_px_next = rdata.price;
          end
        end
        if (cnt == NSLOT && !pv) state_next = S_EVAL;
      end
      S_EVAL: begin
        unique case (stg)
          STG_TOP: begin
            if (!out_busy) begin
              load_status = 1'b1;
              state_next  = S_IDLE;
            end
          end
          STG_CROSS: do_cross = 1'b1;
          STG_FIRST: begin
            case (c_req)
              REQ_ADD: begin
                if (add_bad) begin
                  c_stat_next = STAT_INVALID; c_left_next = c_rem;
                  stg_next = STG_TOP; go_scan = 1'b1;
                end else if (c_otype == OT_FOK && avail < AVW'(c_rem)) begin
                  c_stat_next = STAT_FOK_REJ; c_left_next = c_rem;
                  stg_next = STG_TOP; go_scan = 1'b1;
                end else begin
                  do_cross = 1'b1;
                end
              end
              REQ_CANCEL: begin
                c_left_next = '0;
                if (match_hit) begin
                  we = 1'b1; waddr = match_idx; wdata = match_w; wdata.valid = 1'b0;
                  c_stat_next = STAT_CANCELLED;
                end else begin
                  c_stat_next = STAT_NOT_FOUND;
                end
                stg_next = STG_TOP; go_scan = 1'b1;
              end
              REQ_MODIFY: begin
                waddr = match_idx;
                wdata = match_w;
                stg_next = STG_TOP;
                go_scan  = 1'b1;
                if (!match_hit) begin
                  c_stat_next = STAT_NOT_FOUND; c_left_next = '0;
                end else if (c_qty == '0 || c_qty < filled) begin
                  c_stat_next = STAT_INVALID; c_left_next = match_w.left;
                end else if (mod_left == '0) begin
                  we = 1'b1; wdata.valid = 1'b0;
                  c_stat_next = STAT_MODIFIED; c_left_next = '0;
                end else if (newp == match_w.price && c_qty <= match_w.total) begin
                  // Priority is kept: the slot is updated where it stands.
                  we = 1'b1; wdata.total = c_qty; wdata.left = mod_left;
                  c_stat_next = STAT_MODIFIED; c_left_next = mod_left;
                end else begin
                  // Remove and re-enter as a fresh limit order.
                  we = 1'b1; wdata.valid = 1'b0;
                  c_side_next  = match_w.side;
                  c_otype_next = OT_LIMIT;
                  c_price_next = newp;
                  c_rem_next   = mod_left;
                  stg_next     = STG_CROSS;
                end
              end
              default: begin
                c_stat_next = STAT_INVALID; c_left_next = '0;
                stg_next = STG_TOP; go_scan = 1'b1;
              end
            endcase
          end
          default: state_next = S_IDLE;
        endcase

        if (do_cross) begin
          if (c_rem != '0 && best_hit) begin
            if (!out_busy) begin
              we          = 1'b1;
              waddr       = best_idx;
              wdata       = best_w;
              wdata.left  = best_w.left - fill;
              wdata.valid = (best_w.left != fill);
              load_trade  = 1'b1;
              c_rem_next  = rem_new;
              stg_next    = STG_CROSS;
              go_scan     = 1'b1;
            end
          end else begin
            c_left_next = c_rem;
            stg_next    = STG_TOP;
            go_scan     = 1'b1;
            if (c_rem == '0) begin
              c_stat_next = STAT_FILLED;
            end else if (c_otype == OT_LIMIT) begin
              if (free_hit) begin
                we            = 1'b1;
                waddr         = free_idx;
                wdata.valid   = 1'b1;
                wdata.id      = c_id;
                wdata.side    = c_side;
                wdata.price   = c_price;
                wdata.total   = c_qty;
                wdata.left    = c_rem;
                wdata.arrival = arr_cnt;
                arr_next      = arr_cnt + 1'b1;
                c_stat_next   = STAT_RESTED;
              end else begin
                c_stat_next = STAT_BOOK_FULL;
              end
            end else begin
              c_stat_next = (c_rem < c_qty) ? STAT_PARTIAL : STAT_CANCELLED;
            end
          end
        end
      end
      default: state_next = S_CLEAR;
    endcase

    if (go_scan) begin
      state_next = S_SCAN;
      cnt_next = '0; pv_next = 1'b0;
      match_hit_next = 1'b0; best_hit_next = 1'b0; free_hit_next = 1'b0;
      bid_hit_next = 1'b0; ask_hit_next = 1'b0; avail_next = '0;
      bid_px_next = '0; ask_px_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      cnt     <= '0;
      pv      <= 1'b0;
      arr_cnt <= '0;
      o_valid <= 1'b0;
      stg     <= STG_FIRST;
    end else begin
      state   <= state_next;
      cnt     <= cnt_next;
      pv      <= pv_next;
      arr_cnt <= arr_next;
      stg     <= stg_next;
      if (load_trade || load_status) o_valid <= 1'b1;
      else if (res.ready)            o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    pidx <= cnt[IDXW-1:0];
    match_hit <= match_hit_next; match_idx <= match_idx_next; match_w <= match_w_next;
    best_hit <= best_hit_next;   best_idx <= best_idx_next;   best_w <= best_w_next;
    free_hit <= free_hit_next;   free_idx <= free_idx_next;   avail <= avail_next;
    bid_hit <= bid_hit_next; bid_px <= bid_px_next;
    ask_hit <= ask_hit_next; ask_px <= ask_px_next;
    c_req <= c_req_next; c_id <= c_id_next; c_side <= c_side_next; c_otype <= c_otype_next;
    c_price <= c_price_next; c_qty <= c_qty_next; c_rem <= c_rem_next;
    c_stat <= c_stat_next; c_left <= c_left_next;
    if (load_trade) begin
      res.result_kind  <= RK_TRADE;
      res.aggressor_id <= c_id;
      res.resting_id   <= best_w.id;
      res.trade_price  <= best_w.price;
      res.trade_qty    <= fill;
      res.left_qty     <= rem_new;
      res.status       <= (rem_new != '0) ? STAT_PARTIAL : STAT_FILLED;
      res.best_bid     <= '0;
      res.best_ask     <= '0;
      res.bid_present  <= 1'b0;
      res.ask_present  <= 1'b0;
      res.last_result  <= 1'b0;
    end else if (load_status) begin
      res.result_kind  <= RK_STATUS;
      res.aggressor_id <= c_id;
      res.resting_id   <= '0;
      res.trade_price  <= '0;
      res.trade_qty    <= '0;
      res.left_qty     <= c_left;
      res.status       <= c_stat;
      res.best_bid     <= bid_px;
      res.best_ask     <= ask_px;
      res.bid_present  <= bid_hit;
      res.ask_present  <= ask_hit;
      res.last_result  <= 1'b1;
    end
  end
endmodule

@@ rtl/limit_order_book_matcher_unit.sv @@
// Top level of the price-time priority order book matcher.
// Each request item adds, cancels or modifies an order held in a store of ORDER_SLOTS
// order slots, and yields zero or more trade items followed by exactly one status item
// that carries the best bid and best ask after the request. Requests are taken by a
// front end that assigns automatic identifiers and queued in a two-entry queue, so new
// items are accepted while the engine works and while a result waits at the output.
// The engine reads the slot store through its single read port, one slot a cycle, in
// passes over the whole book, each followed by a decision. A cancel, an invalid
// request or a simple modify takes two passes; an add that makes T trades takes T + 2
// passes; a modify that re-enters adds one more pass. A trade or status item also
// waits for as long as the previous result item has not been taken at the output.
// After reset the store is cleared, one slot a cycle, during which no request item
// is taken by the engine (up to two wait in the queue).
module limit_order_book_matcher_unit import ordm_pkg::*; #(
  parameter int ORDER_SLOTS = 32,
  parameter int PRICE_BITS  = 16,
  parameter int QTY_BITS    = 20,
  parameter int ID_BITS     = 32
) (
  input logic        clk,
  input logic        rst,
  ordm_req_if.sink   req,
  ordm_res_if.source res
);
  localparam int REQ_W = 2 + ID_BITS + 1 + 2 + PRICE_BITS + 2 * QTY_BITS;

  // Request words pass from the front end to the engine through the queue.
  logic             push, full, pop, not_empty;
  logic [REQ_W-1:0] push_data, pop_data;

  ordm_front #(
    .PRICE_BITS(PRICE_BITS), .QTY_BITS(QTY_BITS), .ID_BITS(ID_BITS)
  ) u_front (
    .clk(clk), .rst(rst), .req(req), .push(push), .push_data(push_data), .full(full)
  );

  ordm_fifo #(.WIDTH(REQ_W)) u_fifo (
    .clk(clk), .rst(rst), .push(push), .push_data(push_data), .full(full),
    .pop(pop), .pop_data(pop_data), .not_empty(not_empty)
  );

  // The engine owns the slot store and the output register.
  ordm_engine #(
    .ORDER_SLOTS(ORDER_SLOTS), .PRICE_BITS(PRICE_BITS), .QTY_BITS(QTY_BITS),
    .ID_BITS(ID_BITS)
  ) u_engine (
    .clk(clk), .rst(rst), .q_valid(not_empty), .q_data(pop_data), .q_pop(pop), .res(res)
  );
endmodule

@@ dv/book_checker.sv @@
// Checker for the order book matcher: predicts every result item and compares it.
module book_checker import ordm_pkg::*; (
  input logic  clk,
  input logic  rst,
  ordm_req_if  req,
  ordm_res_if  res,
  output int   errors,
  output int   pending
);

  localparam int SLOTS = 32;

  typedef struct packed {
    logic        kind;
    logic [31:0] aggr;
    logic [31:0] rest;
    logic [15:0] tprice;
    logic [19:0] tqty;
    logic [19:0] left;
    logic [3:0]  stat;
    logic [15:0] bid;
    logic [15:0] ask;
    logic        bidp;
    logic        askp;
    logic        last;
  } result_t;

  result_t     due_q[$];

  logic        bk_valid[SLOTS];
  logic [31:0] bk_id[SLOTS];
  logic        bk_side[SLOTS];
  logic [15:0] bk_price[SLOTS];
  logic [19:0] bk_total[SLOTS];
  logic [19:0] bk_left[SLOTS];
  logic [31:0] bk_arr[SLOTS];
  logic [31:0] arr_count;
  logic [31:0] auto_id;

  function automatic int find_order(logic [31:0] id);
    for (int i = 0; i < SLOTS; i++)
      if (bk_valid[i] && bk_id[i] == id) return i;
    return -1;
  endfunction

  function automatic bit crosses(int i, logic sd, bit mkt, logic [15:0] lim);
    if (!bk_valid[i] || bk_side[i] == sd) return 0;
    if (mkt) return 1;
    return sd == SIDE_BUY ? bk_price[i] <= lim : bk_price[i] >= lim;
  endfunction

  function automatic int best_match(logic sd, bit mkt, logic [15:0] lim);
    int b;
    b = -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (!crosses(i, sd, mkt, lim)) continue;
      if (b < 0) b = i;
      else if (bk_price[i] != bk_price[b]) begin
        if (sd == SIDE_BUY ? bk_price[i] < bk_price[b] : bk_price[i] > bk_price[b]) b = i;
      end else if (32'(arr_count - bk_arr[i]) > 32'(arr_count - bk_arr[b])) begin
        b = i;
      end
    end
    return b;
  endfunction

  // The status item always reports the top of the book after the request.
  function automatic void push_status(logic [31:0] id, logic [19:0] left, status_t st);
    result_t r;
    r = '0;
    r.kind = RK_STATUS;
    r.aggr = id;
    r.left = left;
    r.stat = st;
    r.last = 1'b1;
    for (int i = 0; i < SLOTS; i++) begin
      if (!bk_valid[i]) continue;
      if (bk_side[i] == SIDE_BUY) begin
        if (!r.bidp || bk_price[i] > r.bid) r.bid = bk_price[i];
        r.bidp = 1'b1;
      end else begin
        if (!r.askp || bk_price[i] < r.ask) r.ask = bk_price[i];
        r.askp = 1'b1;
      end
    end
    due_q = {due_q, r};
  endfunction

  function automatic void run_add(logic [31:0] id, logic sd, ord_type_t ot,
                                  logic [15:0] pr, logic [19:0] qty, logic [19:0] rem);
    bit mkt;
    longint avail;
    int k, f;
    logic [19:0] fill;
    result_t r;
    status_t st;
    mkt = (ot == OT_MARKET);
    if (qty == 0 || rem == 0 || rem > qty || (!mkt && pr == 0) || find_order(id) >= 0) begin
      push_status(id, rem, STAT_INVALID);
      return;
    end
    if (ot == OT_FOK) begin
      avail = 0;
      for (int i = 0; i < SLOTS; i++)
        if (crosses(i, sd, mkt, pr)) avail += bk_left[i];
      if (avail < rem) begin
        push_status(id, rem, STAT_FOK_REJ);
        return;
      end
    end
    while (rem > 0) begin
      k = best_match(sd, mkt, pr);
      if (k < 0) break;
      fill = rem < bk_left[k] ? rem : bk_left[k];
      rem -= fill;
      bk_left[k] -= fill;
      r = '0;
      r.kind = RK_TRADE;
      r.aggr = id;
      r.rest = bk_id[k];
      r.tprice = bk_price[k];
      r.tqty = fill;
      r.left = rem;
      r.stat = rem > 0 ? STAT_PARTIAL : STAT_FILLED;
      due_q = {due_q, r};
      if (bk_left[k] == 0) bk_valid[k] = 1'b0;
    end
    if (rem == 0) st = STAT_FILLED;
    else if (ot == OT_LIMIT) begin
      f = -1;
      for (int i = 0; i < SLOTS; i++)
        if (!bk_valid[i]) begin
          f = i;
          break;
        end
      if (f < 0) st = STAT_BOOK_FULL;
      else begin
        bk_valid[f] = 1'b1;
        bk_id[f] = id;
        bk_side[f] = sd;
        bk_price[f] = pr;
        bk_total[f] = qty;
        bk_left[f] = rem;
        bk_arr[f] = arr_count;
        arr_count++;
        st = STAT_RESTED;
      end
    end else st = rem < qty ? STAT_PARTIAL : STAT_CANCELLED;
    push_status(id, rem, st);
  endfunction

  function automatic void apply_request();
    logic [31:0] id;
    logic [19:0] rem, filled, left;
    logic [15:0] np;
    int k;
    id = req.ord_id;
    case (req.req_type)
      REQ_ADD: begin
        if (id == 0) begin
          id = auto_id;
          auto_id++;
          if (auto_id == 0) auto_id = 1;
        end
        rem = req.unfilled_qty == 0 ? req.quantity : req.unfilled_qty;
        run_add(id, req.side, ord_type_t'(req.order_type), req.price, req.quantity, rem);
      end
      REQ_CANCEL: begin
        k = find_order(id);
        if (k < 0) push_status(id, 0, STAT_NOT_FOUND);
        else begin
          bk_valid[k] = 1'b0;
          push_status(id, 0, STAT_CANCELLED);
        end
      end
      REQ_MODIFY: begin
        k = find_order(id);
        if (k < 0) push_status(id, 0, STAT_NOT_FOUND);
        else begin
          filled = bk_total[k] - bk_left[k];
          if (req.quantity == 0 || req.quantity < filled)
            push_status(id, bk_left[k], STAT_INVALID);
          else begin
            left = req.quantity - filled;
            np = req.price != 0 ? req.price : bk_price[k];
            if (left == 0) begin
              bk_valid[k] = 1'b0;
              push_status(id, 0, STAT_MODIFIED);
            end else if (np == bk_price[k] && req.quantity <= bk_total[k]) begin
              bk_total[k] = req.quantity;
              bk_left[k] = left;
              push_status(id, left, STAT_MODIFIED);
            end else begin
              bk_valid[k] = 1'b0;
              run_add(id, bk_side[k], OT_LIMIT, np, req.quantity, left);
            end
          end
        end
      end
      default: push_status(id, 0, STAT_INVALID);
    endcase
  endfunction

  function automatic void check_result();
    result_t got, want;
    got = {res.result_kind, res.aggressor_id, res.resting_id, res.trade_price,
           res.trade_qty, res.left_qty, res.status, res.best_bid, res.best_ask,
           res.bid_present, res.ask_present, res.last_result};
    if (due_q.size() == 0) begin
      $display("%0t: unexpected result item %h", $time, got);
      errors++;
      return;
    end
    want = due_q[0];
    due_q.delete(0);
    if (got.kind != want.kind || got.aggr != want.aggr || got.rest != want.rest ||
        got.tprice != want.tprice || got.tqty != want.tqty || got.left != want.left ||
        got.stat != want.stat || got.bid != want.bid || got.ask != want.ask ||
        got.bidp != want.bidp || got.askp != want.askp || got.last != want.last) begin
      $display("%0t: mismatch expected %p actual %p", $time, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) bk_valid[i] = 1'b0;
      arr_count = 0;
      auto_id = 1;
      due_q.delete();
      errors = 0;
      pending = 0;
    end else begin
      // Results are checked before the request of the same edge is applied,
      // since a result can never belong to a request taken at that edge.
      if (res.valid && res.ready) check_result();
      if (req.valid && req.ready) apply_request();
      pending = due_q.size();
    end
  end

endmodule

@@ dv/tb.sv @@
// Testbench top: drives requests into the order book matcher and gives the verdict.
module tb import ordm_pkg::*;;

  localparam logic [1:0] REQ_UNKNOWN = 2'd3;
  localparam logic       SIDE_SELL   = 1'b1;

  logic clk;
  logic rst;
  int   errors;
  int   pending;
  int   cycles = 0;
  int   sent;
  bit   calm;
  int   pool[$];

  ordm_req_if req();
  ordm_res_if res();

  limit_order_book_matcher_unit i_dut (.clk(clk), .rst(rst), .req(req), .res(res));
  book_checker i_chk (.clk(clk), .rst(rst), .req(req), .res(res), .errors(errors),
                      .pending(pending));

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Watchdog: at most 34 passes per request, plus stalls on both sides.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("tb failed");
      $finish;
    end
  end

  // Result side back-pressure comes in bursts and stops near the end.
  initial begin
    res.ready = 1'b0;
    @(posedge clk);
    forever begin
      res.ready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
      if (!calm && $urandom_range(0, 2) == 0) begin
        res.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
    end
  end

  task automatic send(logic [1:0] rt, logic [31:0] id, logic sd, ord_type_t ot,
                      logic [15:0] pr, logic [19:0] qty, logic [19:0] rem);
    req.valid        <= 1'b1;
    req.req_type     <= rt;
    req.ord_id       <= id;
    req.side         <= sd;
    req.order_type   <= ot;
    req.price        <= pr;
    req.quantity     <= qty;
    req.unfilled_qty <= rem;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    sent++;
    if (!calm && $urandom_range(0, 3) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  // Random requests mostly use a narrow band of prices and small quantities, so that
  // orders cross; cancels and modifies mostly refer to identifiers seen before.
  task automatic random_request();
    int r;
    logic [31:0] id;
    logic [15:0] pr;
    logic [19:0] qty;
    r = $urandom_range(0, 99);
    id = (pool.size() > 0 && $urandom_range(0, 3) != 0) ?
         pool[$urandom_range(0, pool.size() - 1)] : $urandom_range(1, 400);
    pr = $urandom_range(0, 9) == 0 ? 16'($urandom) : 16'($urandom_range(95, 105));
    qty = $urandom_range(0, 15) == 0 ? 20'($urandom) : 20'($urandom_range(1, 40));
    if (r < 60) begin
      if ($urandom_range(0, 2) == 0) id = 0;
      else id = $urandom_range(1, 400);
      pool = {pool, int'(id)};
      send(REQ_ADD, id, 1'($urandom), ord_type_t'($urandom_range(0, 3)), pr, qty,
           $urandom_range(0, 4) == 0 ? 20'($urandom_range(0, qty)) : 20'd0);
    end else if (r < 75) send(REQ_CANCEL, id, 1'($urandom), OT_LIMIT, pr, qty, 0);
    else if (r < 95)
      send(REQ_MODIFY, id, 1'($urandom), OT_LIMIT, $urandom_range(0, 1) ? 16'd0 : pr,
           $urandom_range(0, 5) == 0 ? 20'd0 : qty, 0);
    else send(REQ_UNKNOWN, $urandom, 1'($urandom), ord_type_t'($urandom_range(0, 3)),
              16'($urandom), 20'($urandom), 20'($urandom));
  endtask

  initial begin
    sent = 0;
    calm = 0;
    rst = 1'b1;
    req.valid = 1'b0;
    req.req_type = REQ_ADD;
    req.ord_id = '0;
    req.side = SIDE_BUY;
    req.order_type = OT_LIMIT;
    req.price = '0;
    req.quantity = '0;
    req.unfilled_qty = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: invalid adds, resting on both sides, crossing, market,
    // IOC, fill or kill, duplicate identifiers, cancel and every modify path.
    send(REQ_ADD, 0, SIDE_BUY, OT_LIMIT, 100, 0, 0);            // quantity zero
    send(REQ_ADD, 0, SIDE_BUY, OT_LIMIT, 0, 10, 0);             // price zero
    send(REQ_ADD, 5, SIDE_BUY, OT_LIMIT, 100, 10, 11);          // remainder too large
    send(REQ_ADD, 10, SIDE_BUY, OT_LIMIT, 100, 10, 0);
    send(REQ_ADD, 10, SIDE_BUY, OT_LIMIT, 100, 10, 0);          // duplicate
    send(REQ_ADD, 11, SIDE_BUY, OT_LIMIT, 100, 20, 5);
    send(REQ_ADD, 12, SIDE_SELL, OT_LIMIT, 16'hFFFF, 20'hFFFFF, 0);
    send(REQ_ADD, 13, SIDE_SELL, OT_LIMIT, 101, 8, 0);
    send(REQ_ADD, 14, SIDE_SELL, OT_FOK, 100, 100, 0);          // rejected
    send(REQ_ADD, 15, SIDE_SELL, OT_FOK, 100, 12, 0);           // two fills
    send(REQ_ADD, 16, SIDE_BUY, OT_IOC, 101, 20, 0);            // partial then drop
    send(REQ_ADD, 17, SIDE_BUY, OT_IOC, 50, 5, 0);              // nothing crosses
    send(REQ_ADD, 32'hFFFF_FFFF, SIDE_BUY, OT_MARKET, 0, 3, 0);
    send(REQ_CANCEL, 32'hFFFF_FFFF, SIDE_BUY, OT_LIMIT, 0, 0, 0); // not found
    send(REQ_ADD, 20, SIDE_BUY, OT_LIMIT, 90, 30, 0);
    send(REQ_MODIFY, 20, SIDE_BUY, OT_LIMIT, 0, 25, 0);         // keeps priority
    send(REQ_MODIFY, 20, SIDE_BUY, OT_LIMIT, 95, 25, 0);        // re-enters
    send(REQ_MODIFY, 20, SIDE_BUY, OT_LIMIT, 0, 0, 0);          // invalid
    send(REQ_MODIFY, 12, SIDE_BUY, OT_LIMIT, 0, 20'hFFFF0, 0);  // keeps priority
    send(REQ_MODIFY, 12, SIDE_BUY, OT_LIMIT, 0, 3, 0);          // equal filled
    send(REQ_MODIFY, 99, SIDE_BUY, OT_LIMIT, 0, 3, 0);
    send(REQ_CANCEL, 20, SIDE_BUY, OT_LIMIT, 0, 0, 0);
    send(REQ_UNKNOWN, 7, SIDE_SELL, OT_FOK, 1, 1, 1);

    // Let the outstanding results drain before filling the book to capacity.
    req.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    for (int i = 0; i < 34; i++)
      send(REQ_ADD, 1000 + i, SIDE_BUY, OT_LIMIT, 16'(10 + i), 1, 0);
    send(REQ_ADD, 0, SIDE_SELL, OT_MARKET, 0, 20, 0);

    for (int i = 0; i < 72; i++) begin
      if (i > 55) calm = 1;
      random_request();
    end
    req.valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0 && pending == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end

endmodule

@@ limit_order_book_matcher_unit.f @@
rtl/ordm_pkg.sv
rtl/ordm_if.sv
rtl/ordm_fifo.sv
rtl/ordm_front.sv
rtl/ordm_engine.sv
rtl/limit_order_book_matcher_unit.sv
dv/book_checker.sv
dv/tb.sv
